// ===== rtl/fpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants of the fit policy block allocator: request and
// response payloads, the search candidate passed along the cell chain, and
// the policy, mode and register codes.
// ----------------------------------------------------------------------------
package fpba_pkg;

    // Table geometry.
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_W     = 16;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // Field widths of the external payloads.
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int CMP_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Fit policy codes; the unused code behaves as first fit.
    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    // Request modes.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  load_index;
        logic [15:0] size;
    } req_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] remaining;
    } rsp_t;

    // Best candidate found so far, handed from cell to cell.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] val;
    } cand_t;

endpackage

// ===== rtl/fit_policy_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Block allocator with first, best and worst fit over a chain of table cells.
// ----------------------------------------------------------------------------
// A load request writes one entry in the cycle it is accepted and gives no
// response. An allocation request searches the first block_count entries,
// with block_count saturated at MAX_BLOCKS, and ends in a registered
// response: the search candidate moves along the chain of entry cells one
// cell per clock, so the walk down the chain sets the latency, and one
// request is in the search at a time. The block returns to idle when the
// response is loaded and only then accepts the next request. A pending
// response does not block acceptance of the next request; a finished search
// waits only if the response register is still occupied. Configuration
// writes are taken in every cycle and must be issued while the block is
// idle.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core
    import fpba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [POLICY_W-1:0]  fit_policy_reg;
    logic [COUNT_W-1:0]   block_count_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_data_reg;

    logic                 accept;
    logic                 load_fire;
    logic                 finish;
    logic                 charge_fire;
    logic [IDX_W-1:0]     load_idx;
    logic [CNT_W-1:0]     count_sat;
    cand_t                cand_sel;
    cand_t                chain [MAX_BLOCKS+1];
    logic [SIZE_W-1:0]    cell_val [MAX_BLOCKS];

    // Handshake and control decode.
    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE);
        accept      = req_valid && req_ready;
        load_idx    = IDX_W'(req_data.load_index);
        load_fire   = accept && (req_data.mode == MODE_LOAD)
                      && (32'(req_data.load_index) < 32'(MAX_BLOCKS));
        cand_sel    = chain[count_reg];
        finish      = (state_reg == ST_SCAN) && (cnt_reg == count_reg)
                      && (!rsp_valid_reg || rsp_ready);
        charge_fire = finish && cand_sel.found;
        if (CMP_W'(block_count_reg) > CMP_W'(MAX_BLOCKS))
            count_sat = CNT_W'(MAX_BLOCKS);
        else
            count_sat = CNT_W'(block_count_reg);
    end

    // Chain of entry cells; the head sees an empty candidate.
    assign chain[0] = '0;

    for (genvar j = 0; j < MAX_BLOCKS; j++)
    begin : g_cell
        fpba_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(j)),
            .fit_policy (fit_policy_reg),
            .load_en    (load_fire && (load_idx == IDX_W'(j))),
            .load_size  (req_data.size),
            .charge_en  (charge_fire && (cand_sel.idx == IDX_W'(j))),
            .size       (size_reg),
            .cand_in    (chain[j]),
            .cand_out   (chain[j+1]),
            .value      (cell_val[j])
        );
    end

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg  <= FIT_FIRST;
            block_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIT_POLICY:  fit_policy_reg  <= POLICY_W'(cfg_data);
                CFG_BLOCK_COUNT: block_count_reg <= COUNT_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer, scan counter and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            size_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && !finish)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (req_data.mode == MODE_REQUEST))
                    begin
                        size_reg  <= req_data.size;
                        count_reg <= count_sat;
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (cnt_reg != count_reg)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (finish)
                    begin
                        rsp_valid_reg <= 1'b1;
                        if (cand_sel.found)
                        begin
                            rsp_data_reg.granted      <= 1'b1;
                            rsp_data_reg.chosen_block <= 4'(cand_sel.idx);
                            rsp_data_reg.remaining    <= cand_sel.val - size_reg;
                        end
                        else
                        begin
                            rsp_data_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // The scan counter never runs past the saturated entry count.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= count_reg))
        else $error("scan counter ran past the entry count");

    // A new response only ever comes out of a finished search.
    a_rsp_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_SCAN))
        else $error("response raised without a search");

    // After a grant the charged entry holds the reported remainder.
    a_charge_written: assert property (@(posedge clk) disable iff (!rst_n)
        charge_fire |=>
            (cell_val[IDX_W'(rsp_data_reg.chosen_block)] == rsp_data_reg.remaining))
        else $error("charged entry disagrees with the response");

    // A granted response names an entry inside the searched range.
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        charge_fire |-> (CNT_W'(cand_sel.idx) < count_reg))
        else $error("grant outside the searched entries");

endmodule

// ===== rtl/fpba_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry of the allocator. The cell holds the entry's remaining
// size, takes loads and charges, and registers the search candidate it
// passes on to the next cell.
// ----------------------------------------------------------------------------
module fpba_cell
    import fpba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    cell_index,
    input  logic [POLICY_W-1:0] fit_policy,
    input  logic                load_en,
    input  logic [SIZE_W-1:0]   load_size,
    input  logic                charge_en,
    input  logic [SIZE_W-1:0]   size,
    input  cand_t               cand_in,
    output cand_t               cand_out,
    output logic [SIZE_W-1:0]   value
);

    logic [SIZE_W-1:0] value_reg;
    logic [SIZE_W-1:0] value_next;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic              fits;
    logic              take;

    // Decide whether this entry beats the candidate arriving from upstream.
    always_comb
    begin
        fits = (value_reg >= size);
        take = fits && (!cand_in.found
                        || ((fit_policy == FIT_BEST) && (value_reg < cand_in.val))
                        || ((fit_policy == FIT_WORST) && (value_reg > cand_in.val)));
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = cell_index;
            cand_next.val   = value_reg;
        end
        else
        begin
            cand_next = cand_in;
        end
    end

    // Entry update: a load writes the size, a charge subtracts the request.
    always_comb
    begin
        if (load_en)
            value_next = load_size;
        else if (charge_en)
            value_next = value_reg - size;
        else
            value_next = value_reg;
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Candidate stage towards the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cand_reg <= '0;
        else
            cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;
    assign value    = value_reg;

endmodule
